// ===== rtl/drd_pkg.sv =====
`default_nettype none

package drd_pkg;

    // default sizes
    localparam int DEF_MAX_DETECTIONS = 1024;
    localparam int DEF_MAX_ROW_LENGTH = 128;

    // field widths
    localparam int VAL_W   = 32;
    localparam int TAG_W   = 32;
    localparam int CLASS_W = 16;
    localparam int DIDX_W  = 10;
    localparam int CFG_IDX_W = 2;

    // input packing: value, frame_tag
    localparam int IN_DATA_W = VAL_W + TAG_W;
    // output packing: frame tag, left, top, right, bottom, confidence, class, detection index
    localparam int OUT_BITS   = TAG_W + 5 * VAL_W + CLASS_W + DIDX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 2'd2;

    // layout codes
    localparam logic LAYOUT_CENTER = 1'b0;
    localparam logic LAYOUT_CORNER = 1'b1;

    // configuration reset values
    localparam logic [7:0]              RST_ROW_LENGTH      = 8'd85;
    localparam logic signed [VAL_W-1:0] RST_SCORE_THRESHOLD = 32'sd16384;

    // round (2c -/+ s + 1) / 2 toward minus infinity, then saturate to 32 bits
    function automatic logic [VAL_W-1:0] corner_round(
        input logic [VAL_W-1:0] c,
        input logic [VAL_W-1:0] s,
        input logic             sub
    );
        logic        [VAL_W+2:0] c2;
        logic        [VAL_W+2:0] se;
        logic signed [VAL_W+2:0] t;
        logic signed [VAL_W+1:0] h;
        logic        [VAL_W-1:0] r;
        c2 = {{2{c[VAL_W-1]}}, c, 1'b0};
        se = {{3{s[VAL_W-1]}}, s};
        t  = sub ? (c2 - se + 35'd1) : (c2 + se + 35'd1);
        h  = t[VAL_W+2:1];
        if (h > 34'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (h < -34'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = h[VAL_W-1:0];
        end
        return r;
    endfunction

    // Q16.16 to integer, truncated toward zero
    function automatic logic [CLASS_W-1:0] q16_to_int(input logic [VAL_W-1:0] raw);
        logic rnd;
        rnd = raw[VAL_W-1] && (raw[15:0] != 16'd0);
        return raw[VAL_W-1:16] + {{(CLASS_W-1){1'b0}}, rnd};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/detection_row_decode_unit.sv =====
`default_nettype none

// output: a detection is registered and appears on the master side in the cycle after
// the transaction that completes its row
// throughput: one input transaction per cycle, held back only while a detection
// waits on m_tready in the output register
// reset: aresetn synchronous active low; clears row and frame state, detection
// count and output valid, and loads the configuration defaults
module detection_row_decode_unit #(
    parameter int MAX_DETECTIONS = drd_pkg::DEF_MAX_DETECTIONS,
    parameter int MAX_ROW_LENGTH = drd_pkg::DEF_MAX_ROW_LENGTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [drd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [drd_pkg::IN_DATA_W-1:0]  s_tdata,   // value, frame_tag
    input  wire logic [0:0]                     s_tuser,   // frame_start
    // detection stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [drd_pkg::OUT_DATA_W-1:0]      m_tdata    // frame tag, left, top, right,
                                                           // bottom, confidence, class,
                                                           // detection_index, zero pad
);

    localparam int IDX_W = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;
    localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);
    localparam int VAL_W = drd_pkg::VAL_W;
    localparam int PAD_W = drd_pkg::OUT_DATA_W - drd_pkg::OUT_BITS;

    // configuration registers
    logic                    layout_mode_reg;
    logic [7:0]              row_length_reg;
    logic signed [VAL_W-1:0] score_threshold_reg;

    // row and frame state
    logic [IDX_W-1:0]        elem_idx_reg,   elem_idx_next;
    logic signed [VAL_W-1:0] best_score_reg, best_score_next;
    logic [IDX_W-1:0]        best_class_reg, best_class_next;
    logic [VAL_W-1:0]        box_reg [4];
    logic [VAL_W-1:0]        box_next [4];
    logic [VAL_W-1:0]        class_raw_reg,  class_raw_next;
    logic [CNT_W-1:0]        det_cnt_reg,    det_cnt_next;

    // output register
    logic                          m_valid_reg;
    logic [drd_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                    in_xfer;
    logic                    emit;
    logic signed [VAL_W-1:0] in_value;
    logic [VAL_W-1:0]        in_tag;
    logic                    in_fs;
    logic [CMP_W-1:0]        len_raw;
    logic [CMP_W-1:0]        len_eff;
    logic [CMP_W-1:0]        idx_ext;
    logic [IDX_W-1:0]        idx_cur;
    logic [CMP_W:0]          idx_plus;
    logic                    row_done;
    logic [CNT_W-1:0]        cnt_cur;
    logic [CNT_W+drd_pkg::DIDX_W-1:0] cnt_wide;
    logic [drd_pkg::CLASS_W-1:0] class_out;
    logic [VAL_W-1:0]        left_v, top_v, right_v, bottom_v;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign in_value = s_tdata[VAL_W-1:0];
    assign in_tag   = s_tdata[drd_pkg::IN_DATA_W-1:VAL_W];
    assign in_fs    = s_tuser[0];

    // effective row length, clamped to 5..MAX_ROW_LENGTH
    assign len_raw = CMP_W'(row_length_reg);
    always_comb begin
        if (len_raw < CMP_W'(5)) begin
            len_eff = CMP_W'(5);
        end else if (len_raw > CMP_W'(MAX_ROW_LENGTH)) begin
            len_eff = CMP_W'(MAX_ROW_LENGTH);
        end else begin
            len_eff = len_raw;
        end
    end

    // element position of this value; a frame start or a shortened row restarts it
    assign idx_ext = CMP_W'(elem_idx_reg);
    always_comb begin
        if (in_fs || (idx_ext >= len_eff)) begin
            idx_cur = '0;
        end else begin
            idx_cur = elem_idx_reg;
        end
    end
    assign idx_plus = (CMP_W + 1)'(idx_cur) + (CMP_W + 1)'(1);
    assign row_done = idx_plus >= {1'b0, len_eff};
    assign cnt_cur  = in_fs ? '0 : det_cnt_reg;

    // row accumulation: box fields, running best score and class
    always_comb begin
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        class_raw_next  = class_raw_reg;
        for (int i = 0; i < 4; i++) begin
            box_next[i] = box_reg[i];
        end
        if (idx_cur == '0) begin
            best_score_next = '0;
            best_class_next = '0;
        end
        if (idx_cur < IDX_W'(4)) begin
            box_next[idx_cur[1:0]] = in_value;
        end else if (layout_mode_reg == drd_pkg::LAYOUT_CENTER) begin
            if (len_eff == CMP_W'(5)) begin
                best_score_next = in_value;
                best_class_next = '0;
            end else if (in_value > best_score_next) begin
                best_score_next = in_value;
                best_class_next = idx_cur - IDX_W'(4);
            end
        end else begin
            if (idx_cur == IDX_W'(4)) begin
                best_score_next = in_value;
            end else if (idx_cur == IDX_W'(5)) begin
                class_raw_next = in_value;
            end
        end
    end

    // keep decision for a completed row
    assign emit = row_done
                && (cnt_cur < CNT_W'(MAX_DETECTIONS))
                && !((layout_mode_reg == drd_pkg::LAYOUT_CORNER) && (len_eff < CMP_W'(6)))
                && !(best_score_next < score_threshold_reg);

    assign elem_idx_next = row_done ? '0 : idx_plus[IDX_W-1:0];
    assign det_cnt_next  = emit ? cnt_cur + CNT_W'(1) : cnt_cur;

    // detection fields
    assign cnt_wide = {{drd_pkg::DIDX_W{1'b0}}, cnt_cur};
    always_comb begin
        if (layout_mode_reg == drd_pkg::LAYOUT_CENTER) begin
            left_v    = drd_pkg::corner_round(box_next[0], box_next[2], 1'b1);
            top_v     = drd_pkg::corner_round(box_next[1], box_next[3], 1'b1);
            right_v   = drd_pkg::corner_round(box_next[0], box_next[2], 1'b0);
            bottom_v  = drd_pkg::corner_round(box_next[1], box_next[3], 1'b0);
            class_out = {{(drd_pkg::CLASS_W - IDX_W){1'b0}}, best_class_next};
        end else begin
            left_v    = box_next[0];
            top_v     = box_next[1];
            right_v   = box_next[2];
            bottom_v  = box_next[3];
            class_out = drd_pkg::q16_to_int(class_raw_next);
        end
    end
    assign m_data_next = {{PAD_W{1'b0}}, cnt_wide[drd_pkg::DIDX_W-1:0], class_out,
                          best_score_next, bottom_v, right_v, top_v, left_v, in_tag};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_mode_reg     <= drd_pkg::LAYOUT_CENTER;
            row_length_reg      <= drd_pkg::RST_ROW_LENGTH;
            score_threshold_reg <= drd_pkg::RST_SCORE_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                drd_pkg::CFG_LAYOUT_MODE:     layout_mode_reg     <= cfg_data[0];
                drd_pkg::CFG_ROW_LENGTH:      row_length_reg      <= cfg_data[7:0];
                drd_pkg::CFG_SCORE_THRESHOLD: score_threshold_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // row and frame state update on each input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_idx_reg   <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            class_raw_reg  <= '0;
            det_cnt_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                box_reg[i] <= '0;
            end
        end else if (in_xfer) begin
            elem_idx_reg   <= elem_idx_next;
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            class_raw_reg  <= class_raw_next;
            det_cnt_reg    <= det_cnt_next;
            for (int i = 0; i < 4; i++) begin
                box_reg[i] <= box_next[i];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && emit) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef ASSERT_OFF
    // detection count never passes the frame limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        det_cnt_reg <= CNT_W'(MAX_DETECTIONS))
        else $error("detection count above limit");

    // every kept row advances the detection count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && emit) |=> (det_cnt_reg == $past(cnt_cur) + CNT_W'(1)))
        else $error("detection count did not advance");

    // a kept row always leaves a detection waiting on the master side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && emit) |=> m_valid_reg)
        else $error("kept row produced no detection");

    // the input side only stalls behind a waiting detection
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire

// ===== bench/detection_row_decode_unit_test.sv =====
module detection_row_decode_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_DET      = drd_pkg::DEF_MAX_DETECTIONS;
    localparam int     MAX_ROW      = drd_pkg::DEF_MAX_ROW_LENGTH;
    localparam int     SETTLE       = 4;
    localparam int     LONG_HOLD    = 300;
    localparam int     DRAIN_LIMIT  = 5000;
    localparam int     PHASE_ITEMS  = 270;
    localparam int     REPORT_LIMIT = 10;
    localparam longint SAT_HI       = 64'sd2147483647;
    localparam longint SAT_LO       = -64'sd2147483648;

    // index that selects no register
    localparam logic [drd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic        [31:0] frame_tag;
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
        logic signed [31:0] confidence;
        logic signed [15:0] class_idx;
        logic        [9:0]  detection_index;
    } detection_t;

    // dut ports
    logic                                aclk;
    logic                                aresetn   = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [drd_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [31:0]                         cfg_data  = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [drd_pkg::IN_DATA_W-1:0]       s_tdata   = '0;   // value, frame_tag
    logic [0:0]                          s_tuser   = '0;   // frame_start
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [drd_pkg::OUT_DATA_W-1:0]      m_tdata;          // frame tag, left, top, right,
                                                           // bottom, confidence, class,
                                                           // detection_index, zero pad

    // configuration as the block should hold it
    logic               cfg_layout    = drd_pkg::LAYOUT_CENTER;
    logic [7:0]         cfg_row_len   = drd_pkg::RST_ROW_LENGTH;
    logic signed [31:0] cfg_threshold = drd_pkg::RST_SCORE_THRESHOLD;

    // row and frame state of the decoder
    int unsigned        cur_elem        = 0;
    logic signed [31:0] row_best_score  = '0;
    int unsigned        row_best_class  = 0;
    logic signed [31:0] box_q[4]        = '{default: '0};
    logic signed [31:0] row_class_word  = '0;
    int unsigned        frame_det_count = 0;

    detection_t expected_detections[$];

    // traffic shaping
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    // bookkeeping
    int items_sent         = 0;
    int detections_checked = 0;
    int config_writes      = 0;
    int mismatch_count     = 0;

    detection_t got_det;
    detection_t want_det;

    detection_row_decode_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // row length as the block uses it
    function automatic int unsigned eff_row_length();
        int unsigned len;
        len = cfg_row_len;
        if (len < 5) len = 5;
        if (len > MAX_ROW) len = MAX_ROW;
        return len;
    endfunction

    // corner from center and size: exact half step, ties up, then saturate
    function automatic logic signed [31:0] corner_pos(input logic signed [31:0] center,
                                                      input logic signed [31:0] size,
                                                      input bit lower);
        longint twice;
        twice = 2 * longint'(center) + 1;
        twice = lower ? twice - longint'(size) : twice + longint'(size);
        twice = twice >>> 1;
        if (twice > SAT_HI) twice = SAT_HI;
        else if (twice < SAT_LO) twice = SAT_LO;
        return twice[31:0];
    endfunction

    // advance the decoder by one accepted value, queue a detection if the row is kept
    function automatic void predict_detection(input logic signed [31:0] value,
                                              input logic frame_start,
                                              input logic [31:0] tag);
        int unsigned len;
        int unsigned idx;
        longint      cls;
        detection_t  det;
        len = eff_row_length();
        if (frame_start) begin
            frame_det_count = 0;
            cur_elem = 0;
        end
        idx = cur_elem;
        if (idx >= len) idx = 0;
        if (idx == 0) begin
            row_best_score = '0;
            row_best_class = 0;
        end
        if (idx < 4) begin
            box_q[idx] = value;
        end else if (cfg_layout == drd_pkg::LAYOUT_CENTER) begin
            if (len == 5) begin
                row_best_score = value;
                row_best_class = 0;
            end else if (value > row_best_score) begin
                row_best_score = value;
                row_best_class = idx - 4;
            end
        end else begin
            if (idx == 4) row_best_score = value;
            else if (idx == 5) row_class_word = value;
        end
        if (idx + 1 < len) begin
            cur_elem = idx + 1;
            return;
        end
        cur_elem = 0;
        if (frame_det_count >= MAX_DET) return;
        if (cfg_layout == drd_pkg::LAYOUT_CORNER && len < 6) return;
        if (row_best_score < cfg_threshold) return;
        det.frame_tag = tag;
        if (cfg_layout == drd_pkg::LAYOUT_CENTER) begin
            det.left      = corner_pos(box_q[0], box_q[2], 1'b1);
            det.top       = corner_pos(box_q[1], box_q[3], 1'b1);
            det.right     = corner_pos(box_q[0], box_q[2], 1'b0);
            det.bottom    = corner_pos(box_q[1], box_q[3], 1'b0);
            det.class_idx = 16'(row_best_class);
        end else begin
            det.left   = box_q[0];
            det.top    = box_q[1];
            det.right  = box_q[2];
            det.bottom = box_q[3];
            // integer part truncated toward zero always fits sixteen bits
            cls = longint'(row_class_word) / 64'sd65536;
            det.class_idx = cls[15:0];
        end
        det.confidence      = row_best_score;
        det.detection_index = 10'(frame_det_count);
        frame_det_count++;
        expected_detections = {expected_detections, det};
    endfunction

    // one input transaction; entered and left at a falling edge
    task automatic send_item(input logic [31:0] value, input logic frame_start,
                             input logic [31:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, value};
        s_tuser  <= frame_start;
        do @(posedge aclk); while (!s_tready);
        predict_detection(value, frame_start, tag);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_row(input logic [31:0] vals[$], input bit new_frame,
                            input logic [31:0] tag);
        foreach (vals[i]) send_item(vals[i], new_frame && (i == 0), tag);
    endtask

    // stop offering and let every pending detection drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_detections.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_register(input logic [drd_pkg::CFG_IDX_W-1:0] index,
                                  input logic [31:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            drd_pkg::CFG_LAYOUT_MODE:     cfg_layout    = data[0];
            drd_pkg::CFG_ROW_LENGTH:      cfg_row_len   = data[7:0];
            drd_pkg::CFG_SCORE_THRESHOLD: cfg_threshold = data;
            default: ;
        endcase
        config_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_decoder(input logic layout, input logic [7:0] len,
                               input logic [31:0] thr);
        logic [31:0] data;
        data = $urandom();
        data[0] = layout;
        write_register(drd_pkg::CFG_LAYOUT_MODE, data);
        data = $urandom();
        data[7:0] = len;
        write_register(drd_pkg::CFG_ROW_LENGTH, data);
        write_register(drd_pkg::CFG_SCORE_THRESHOLD, thr);
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each detection transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_det.frame_tag       = m_tdata[31:0];
            got_det.left            = m_tdata[63:32];
            got_det.top             = m_tdata[95:64];
            got_det.right           = m_tdata[127:96];
            got_det.bottom          = m_tdata[159:128];
            got_det.confidence      = m_tdata[191:160];
            got_det.class_idx       = m_tdata[207:192];
            got_det.detection_index = m_tdata[217:208];
            if (expected_detections.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected detection: %h", m_tdata);
            end else begin
                want_det = expected_detections.pop_front();
                detections_checked++;
                if (got_det.frame_tag !== want_det.frame_tag ||
                    got_det.left !== want_det.left ||
                    got_det.top !== want_det.top ||
                    got_det.right !== want_det.right ||
                    got_det.bottom !== want_det.bottom ||
                    got_det.confidence !== want_det.confidence ||
                    got_det.class_idx !== want_det.class_idx ||
                    got_det.detection_index !== want_det.detection_index) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch exp: id=%h l=%h t=%h r=%h b=%h c=%h cls=%h n=%0d",
                                 want_det.frame_tag, want_det.left, want_det.top,
                                 want_det.right, want_det.bottom, want_det.confidence,
                                 want_det.class_idx, want_det.detection_index);
                        $display("         got: id=%h l=%h t=%h r=%h b=%h c=%h cls=%h n=%0d",
                                 got_det.frame_tag, got_det.left, got_det.top,
                                 got_det.right, got_det.bottom, got_det.confidence,
                                 got_det.class_idx, got_det.detection_index);
                    end
                end
            end
        end
    end

    // random field values
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom();
            default: return $urandom_range(0, 32'h007f_ffff) - 32'h0040_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_score();
        case ($urandom_range(7))
            0:       return $urandom();
            1:       return cfg_threshold;
            2:       return cfg_threshold - 1;
            default: return cfg_threshold + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_class_word();
        if ($urandom_range(4) == 0) return $urandom();
        return {16'($urandom_range(0, 200) - 100), 16'($urandom())};
    endfunction

    // defaults after reset: center layout, 85 values, threshold of a quarter
    task automatic test_reset_defaults();
        logic [31:0] row[$];
        int          hot;
        hot = $urandom_range(4, 84);
        row = '{32'h0064_0000, 32'h0032_0000, 32'h0010_8000, 32'h0007_0001};
        for (int i = 4; i < 85; i++)
            row = {row, (i == hot) ? 32'h0000_4000 : 32'($urandom_range(0, 16383))};
        send_row(row, 1'b1, $urandom());
        wait_idle();
    endtask

    // extremes, saturation, rounding ties, five-channel and corner rows
    task automatic test_directed_rows();
        logic [31:0] row[$];
        // saturated corners, zero score kept at zero threshold
        set_decoder(drd_pkg::LAYOUT_CENTER, 8'd5, 32'h0000_0000);
        row = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000};
        send_row(row, 1'b1, 32'hffff_ffff);
        // five channels: negative score still used, half-step ties
        write_register(drd_pkg::CFG_SCORE_THRESHOLD, 32'hffff_fffe);
        row = '{32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0003, 32'hffff_ffff};
        send_row(row, 1'b0, 32'h0000_0000);
        // highest threshold: equal kept, one below dropped
        write_register(drd_pkg::CFG_SCORE_THRESHOLD, 32'h7fff_ffff);
        row = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff};
        send_row(row, 1'b0, 32'h1234_5678);
        row = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_fffe};
        send_row(row, 1'b0, 32'h1234_5678);
        // lowest threshold with the most negative values
        write_register(drd_pkg::CFG_SCORE_THRESHOLD, 32'h8000_0000);
        row = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_row(row, 1'b0, 32'h8765_4321);
        // class scores: strict maximum, all-negative row keeps zero and class 0
        set_decoder(drd_pkg::LAYOUT_CENTER, 8'd7, 32'h0000_0000);
        row = '{32'h0001_0000, 32'h0002_0000, 32'h0000_4000, 32'h0000_2000,
                32'h0000_0005, 32'h0000_0005, 32'h0000_0003};
        send_row(row, 1'b1, $urandom());
        row = '{32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_fffe, 32'hffff_fffd};
        send_row(row, 1'b0, $urandom());
        row = '{32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_fffe, 32'h0000_0004};
        send_row(row, 1'b0, $urandom());
        // corner rows: class truncated toward zero, both class extremes, dropped score
        set_decoder(drd_pkg::LAYOUT_CORNER, 8'd6, 32'h0000_0000);
        row = '{32'h10, 32'h20, 32'h30, 32'h40, 32'h0001_0000, 32'hfffe_8000};
        send_row(row, 1'b1, $urandom());
        row = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0,
                32'h7fff_ffff, 32'h7fff_ffff};
        send_row(row, 1'b0, $urandom());
        row = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h0000_0001, 32'h8000_0000};
        send_row(row, 1'b0, $urandom());
        row = '{32'h1, 32'h2, 32'h3, 32'h4, 32'hffff_ffff, 32'h0003_0000};
        send_row(row, 1'b0, $urandom());
        // corner layout with a five-value row never emits
        write_register(drd_pkg::CFG_ROW_LENGTH, 32'h0000_0005);
        row = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h7fff_ffff};
        send_row(row, 1'b0, $urandom());
        // an extra element beyond the class is ignored
        write_register(drd_pkg::CFG_ROW_LENGTH, 32'h0000_0007);
        row = '{32'h5, 32'h6, 32'h7, 32'h8, 32'h0000_9000, 32'h0002_ffff, 32'hdead_beef};
        send_row(row, 1'b0, $urandom());
        // frame start in the middle of a row restarts the row and the count
        set_decoder(drd_pkg::LAYOUT_CENTER, 8'd6, 32'h8000_0000);
        row = '{32'h1, 32'h2, 32'h3};
        send_row(row, 1'b0, $urandom());
        row = '{32'h0001_0000, 32'h0001_0000, 32'h0000_0002, 32'h0000_0002,
                32'h0000_0001, 32'h0000_0002};
        send_row(row, 1'b1, $urandom());
        // write to an unused index has no effect
        write_register(CFG_UNUSED_INDEX, $urandom());
        row = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6};
        send_row(row, 1'b0, $urandom());
        wait_idle();
    endtask

    // length changed while a row is partly in
    task automatic test_row_length_change();
        logic [31:0] row[$];
        set_decoder(drd_pkg::LAYOUT_CENTER, 8'd10, 32'h0000_0000);
        row = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7};
        send_row(row, 1'b1, $urandom());
        // index already past the new length: next value starts a fresh row
        write_register(drd_pkg::CFG_ROW_LENGTH, 32'h0000_0006);
        row = '{32'h0002_0000, 32'h0003_0000, 32'h0000_8000, 32'h0001_8000,
                32'h0000_0100, 32'h0000_0200};
        send_row(row, 1'b0, $urandom());
        row = '{32'h11, 32'h12, 32'h13};
        send_row(row, 1'b0, $urandom());
        // longer length: the row just runs on
        write_register(drd_pkg::CFG_ROW_LENGTH, 32'h0000_0008);
        row = '{32'h14, 32'h0000_0300, 32'h0000_0400, 32'h0000_0100, 32'h0000_0500};
        send_row(row, 1'b0, $urandom());
        wait_idle();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        set_decoder(drd_pkg::LAYOUT_CENTER, 8'd5, 32'h8000_0000);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        for (int r = 0; r < 60; r++)
            for (int i = 0; i < 5; i++) send_item($urandom(), r == 0 && i == 0, $urandom());
        wait_idle();
    endtask

    // a row of random content, sometimes cut short or broken by a stray frame start
    task automatic send_random_row(input int unsigned len, input bit new_frame,
                                   input logic [31:0] tag);
        logic [31:0] v;
        logic [31:0] t;
        int unsigned stop_at;
        stop_at = ($urandom_range(99) < 3) ? $urandom_range(1, len - 1) : len;
        for (int unsigned i = 0; i < stop_at; i++) begin
            t = ($urandom_range(99) < 3) ? $urandom() : tag;
            if (i < 4) v = pick_coord();
            else if (cfg_layout == drd_pkg::LAYOUT_CORNER && i == 5) v = pick_class_word();
            else if (cfg_layout == drd_pkg::LAYOUT_CORNER && i > 5) v = $urandom();
            else v = pick_score();
            send_item(v, new_frame && (i == 0), t);
            if ($urandom_range(99) < 2) send_item($urandom(), 1'b1, $urandom());
        end
    endtask

    // random settings and frames under one idling pattern
    task automatic test_random_traffic(input int idle, input int stall);
        int          start_items;
        int          pick;
        int          rows;
        logic [7:0]  len;
        logic [31:0] thr;
        logic [31:0] tag;
        send_idle_pct = idle;
        stall_pct = stall;
        start_items = items_sent;
        while (items_sent - start_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) len = 8'($urandom_range(5, 10));
            else if (pick < 85) len = 8'($urandom_range(11, 40));
            else if (pick < 90) len = 8'd128;
            else if (pick < 95) len = 8'($urandom_range(0, 4));
            else len = 8'($urandom_range(129, 255));
            pick = $urandom_range(19);
            if (pick == 0) thr = 32'h8000_0000;
            else if (pick == 1) thr = 32'h7fff_ffff;
            else if (pick == 2) thr = $urandom();
            else thr = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            set_decoder(1'($urandom_range(1)), len, thr);
            repeat ($urandom_range(1, 3)) begin
                tag = $urandom();
                rows = (eff_row_length() > 40) ? 1 : $urandom_range(1, 6);
                for (int r = 0; r < rows; r++)
                    send_random_row(eff_row_length(), r == 0, tag);
            end
        end
        wait_idle();
    endtask

    // test sequence
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_directed_rows();
        test_row_length_change();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(75, 0);
        test_random_traffic(0, 75);
        test_random_traffic(21, 21);

        // bounded drain, then a settling wait for stray detections
        s_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_detections.size() != 0; n++)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (expected_detections.size() != 0) begin
            $display("%0d expected detections never arrived", expected_detections.size());
            mismatch_count += expected_detections.size();
        end

        $display("run: %0d stream transactions, %0d detections checked, %0d register writes",
                 items_sent, detections_checked, config_writes);
        $display("run: both layouts, clamped and changed row lengths, threshold extremes, "
                 , "stray frame starts, long output stall");
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
